// File: rtl/msps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo pulse sequencer package
// Shared widths, reset values, item and register codes and the sequencer
// state type.
// ----------------------------------------------------------------------------
package msps_pkg;

	localparam int CHANNELS_DEF = 12;
	localparam int PINS         = 12;
	localparam int PULSE_W      = 12;
	localparam int VALUE_W      = 16;
	localparam int PERIOD_W     = 16;
	localparam int ELAPSED_W    = 17;
	localparam int KIND_W       = 2;
	localparam int CHAN_W       = 4;
	localparam int ANGLE_W      = 8;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;
	localparam int DIVN_W       = 20;
	localparam int DIVD_W       = 12;
	localparam int PROD_W       = 22;
	localparam int US_W         = 18;

	localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ENABLE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DISABLE = 2'd2;
	localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_PULSE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD  = 2'd3;

	localparam logic [PULSE_W-1:0]  MIN_PULSE_RST     = 12'd544;
	localparam logic [PULSE_W-1:0]  MAX_PULSE_RST     = 12'd2400;
	localparam logic [PULSE_W-1:0]  DEFAULT_PULSE_RST = 12'd1500;
	localparam logic [PERIOD_W-1:0] FRAME_PERIOD_RST  = 16'd20000;

	localparam logic [ANGLE_W-1:0]          ANGLE_MAX   = 8'd180;
	localparam logic signed [VALUE_W-1:0]   ANGLE_LIMIT = 16'sd200;
	localparam logic [ELAPSED_W-1:0]        ELAPSED_MAX = 17'h1FFFF;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SEARCH,
		ST_LOAD,
		ST_WDIV_GO,
		ST_WDIV,
		ST_WSTORE,
		ST_RB_RD,
		ST_RB_MUL,
		ST_RB_DIV_GO,
		ST_RB_DIV,
		ST_DONE
	} state_t;

endpackage

// File: rtl/msps_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module msps_ram #(
	parameter int WIDTH = msps_pkg::PULSE_W,
	parameter int DEPTH = msps_pkg::CHANNELS_DEF
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/msps_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divider
// Unsigned restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module msps_div #(
	parameter int N_W = msps_pkg::DIVN_W,
	parameter int D_W = msps_pkg::DIVD_W
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] dividend,
	input  logic [D_W-1:0] divisor,
	output logic           done,
	output logic [N_W-1:0] quotient
);

	localparam int CNT_W = $clog2(N_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [N_W-1:0]   quo_q;
	logic [D_W-1:0]   rem_q;
	logic [D_W-1:0]   dvs_q;
	logic [D_W:0]     shifted;
	logic [D_W:0]     diff;
	logic             ge;

	always_comb begin
		shifted = {rem_q, quo_q[N_W-1]};
		diff    = shifted - {1'b0, dvs_q};
		ge      = shifted >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(N_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[N_W-2:0], ge};
			rem_q <= ge ? diff[D_W-1:0] : shifted[D_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: rtl/multichannel_servo_pulse_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multichannel servo pulse sequencer
// Takes one item at a time. Angle writes and the readback angle share the
// 20-step serial divider. A tick's slot search visits one channel per cycle.
// A new item is taken while the previous result waits in the output register.
// Asynchronous reset clears the control and configuration state at once; there
// is no clearing pass. Payload registers and the pulse RAM are not reset.
// ----------------------------------------------------------------------------
module multichannel_servo_pulse_sequencer #(
	parameter int CHANNELS = msps_pkg::CHANNELS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [msps_pkg::KIND_W-1:0]          kind,
	input  logic [msps_pkg::CHAN_W-1:0]          channel,
	input  logic signed [msps_pkg::VALUE_W-1:0]  value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [msps_pkg::PINS-1:0]            pin_levels,
	output logic [msps_pkg::CHAN_W-1:0]          pulsing_channel,
	output logic [msps_pkg::PULSE_W-1:0]         readback_pulse,
	output logic [msps_pkg::ANGLE_W-1:0]         readback_angle,
	output logic                                 readback_enabled,
	input  logic                                 cfg_wen,
	input  logic [msps_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [msps_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SLOT_W = $clog2(CHANNELS + 1);
	localparam logic [SLOT_W-1:0] SLOT_IDLE = SLOT_W'(CHANNELS);

	msps_pkg::state_t state_q, state_n;

	logic [msps_pkg::PULSE_W-1:0]     min_q, max_q, def_q;
	logic [msps_pkg::PERIOD_W-1:0]    period_q;
	logic [CHANNELS-1:0]              en_q, vld_q;
	logic [SLOT_W-1:0]                slot_q, srch_q;
	logic [msps_pkg::PERIOD_W-1:0]    rem_q;
	logic [msps_pkg::ELAPSED_W-1:0]   elapsed_q;
	logic                             rd_vld_q;
	logic                             out_valid_q;

	logic [msps_pkg::KIND_W-1:0]         kind_q;
	logic [msps_pkg::CHAN_W-1:0]         chan_q;
	logic signed [msps_pkg::VALUE_W-1:0] value_q;
	logic signed [msps_pkg::PROD_W-1:0]  prod_q;
	logic signed [msps_pkg::US_W-1:0]    us_q;
	logic [msps_pkg::PULSE_W-1:0]        rb_pulse_q;
	logic [msps_pkg::ANGLE_W-1:0]        rb_angle_q;
	logic                                rb_en_q;
	logic [msps_pkg::PINS-1:0]           pins_q;
	logic [msps_pkg::CHAN_W-1:0]         pch_q;
	logic [msps_pkg::PULSE_W-1:0]        opulse_q;
	logic [msps_pkg::ANGLE_W-1:0]        oangle_q;
	logic                                oen_q;

	logic                             chan_ok;
	logic [IDX_W-1:0]                 chan_idx, srch_idx;
	logic                             srch_end;
	logic signed [12:0]               span;
	logic [12:0]                      span_mag;
	logic [msps_pkg::PULSE_W-1:0]     pulse_rd;
	logic [msps_pkg::ANGLE_W-1:0]     angle_in;
	logic signed [msps_pkg::PROD_W-1:0] wprod, rprod;
	logic signed [12:0]               diff_rb;
	logic [msps_pkg::PROD_W-1:0]      prod_mag;
	logic signed [msps_pkg::US_W-1:0] q18, qs, us_ang, min18, max18, us_lo, us_cl;
	logic [msps_pkg::PERIOD_W-1:0]    gap;
	logic [msps_pkg::ELAPSED_W-1:0]   elapsed_inc;
	logic [msps_pkg::PERIOD_W-1:0]    rem_dec;
	logic                             tick_event;
	logic [msps_pkg::ANGLE_W-1:0]     rb_angle_n;
	logic                             load_out;
	logic [msps_pkg::PINS-1:0]        pins_n;
	logic [4:0]                       slot5;
	msps_pkg::state_t                 after_st;

	logic                             ram_we;
	logic [IDX_W-1:0]                 ram_raddr;
	logic [msps_pkg::PULSE_W-1:0]     ram_wdata, ram_rdata;
	logic                             div_start, div_done;
	logic [msps_pkg::DIVD_W-1:0]      div_divisor;
	logic [msps_pkg::DIVN_W-1:0]      div_quo;

	msps_ram #(
		.WIDTH(msps_pkg::PULSE_W),
		.DEPTH(CHANNELS)
	) u_pulse_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(chan_idx),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	msps_div #(
		.N_W(msps_pkg::DIVN_W),
		.D_W(msps_pkg::DIVD_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(prod_mag[msps_pkg::DIVN_W-1:0]),
		.divisor (div_divisor),
		.done    (div_done),
		.quotient(div_quo)
	);

	// Datapath terms.
	always_comb begin
		chan_ok  = {1'b0, chan_q} < 5'(CHANNELS);
		chan_idx = chan_q[IDX_W-1:0];
		srch_idx = srch_q[IDX_W-1:0];
		srch_end = srch_q >= SLOT_IDLE;
		span     = $signed({1'b0, max_q}) - $signed({1'b0, min_q});
		span_mag = span[12] ? 13'(-span) : 13'(span);
		pulse_rd = ram_rdata & {msps_pkg::PULSE_W{rd_vld_q}};

		if (value_q < 0) begin
			angle_in = '0;
		end else if (value_q > $signed({8'd0, msps_pkg::ANGLE_MAX})) begin
			angle_in = msps_pkg::ANGLE_MAX;
		end else begin
			angle_in = value_q[msps_pkg::ANGLE_W-1:0];
		end
		wprod    = span * $signed({1'b0, angle_in});
		diff_rb  = $signed({1'b0, pulse_rd}) - $signed({1'b0, min_q});
		rprod    = diff_rb * $signed({1'b0, msps_pkg::ANGLE_MAX});
		prod_mag = prod_q[msps_pkg::PROD_W-1] ? msps_pkg::PROD_W'(-prod_q)
		                                      : msps_pkg::PROD_W'(prod_q);
		div_divisor = (state_q == msps_pkg::ST_WDIV_GO)
		              ? {4'd0, msps_pkg::ANGLE_MAX} : span_mag[msps_pkg::DIVD_W-1:0];

		q18    = $signed({1'b0, div_quo[16:0]});
		qs     = prod_q[msps_pkg::PROD_W-1] ? -q18 : q18;
		min18  = $signed({6'd0, min_q});
		max18  = $signed({6'd0, max_q});
		us_ang = min18 + qs;
		us_lo  = (us_q < min18) ? min18 : us_q;
		us_cl  = (us_lo > max18) ? max18 : us_lo;

		if ((prod_q[msps_pkg::PROD_W-1] ^ span[12]) == 1'b1) begin
			rb_angle_n = '0;
		end else if (div_quo > msps_pkg::DIVN_W'(msps_pkg::ANGLE_MAX)) begin
			rb_angle_n = msps_pkg::ANGLE_MAX;
		end else begin
			rb_angle_n = div_quo[msps_pkg::ANGLE_W-1:0];
		end

		gap = (elapsed_q < {1'b0, period_q})
		      ? period_q - elapsed_q[msps_pkg::PERIOD_W-1:0] : '0;
		elapsed_inc = (elapsed_q == msps_pkg::ELAPSED_MAX)
		              ? elapsed_q : elapsed_q + 17'd1;
		rem_dec     = (rem_q != '0) ? rem_q - 16'd1 : rem_q;
		tick_event  = rem_dec == '0;

		slot5 = 5'(slot_q);
		for (int i = 0; i < msps_pkg::PINS; i++) begin
			pins_n[i] = (i < CHANNELS) && (slot5 == 5'(i));
		end

		after_st  = chan_ok ? msps_pkg::ST_RB_RD : msps_pkg::ST_DONE;
		ram_wdata = (kind_q == msps_pkg::KIND_ENABLE) ? def_q : us_cl[msps_pkg::PULSE_W-1:0];
		load_out  = !out_valid_q || out_ready;
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msps_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n   = state_q;
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_raddr = chan_idx;
		div_start = 1'b0;
		case (state_q)
			msps_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_n = msps_pkg::ST_EXEC;
				end
			end
			msps_pkg::ST_EXEC: begin
				case (kind_q)
					msps_pkg::KIND_TICK: begin
						state_n = tick_event ? msps_pkg::ST_SEARCH : after_st;
					end
					msps_pkg::KIND_ENABLE: begin
						ram_we  = chan_ok;
						state_n = after_st;
					end
					msps_pkg::KIND_WRITE: begin
						if (!chan_ok) begin
							state_n = msps_pkg::ST_DONE;
						end else if (value_q >= msps_pkg::ANGLE_LIMIT) begin
							state_n = msps_pkg::ST_WSTORE;
						end else begin
							state_n = msps_pkg::ST_WDIV_GO;
						end
					end
					default: begin
						state_n = after_st;
					end
				endcase
			end
			msps_pkg::ST_SEARCH: begin
				ram_raddr = srch_idx;
				if (srch_end) begin
					state_n = after_st;
				end else if (en_q[srch_idx]) begin
					state_n = msps_pkg::ST_LOAD;
				end
			end
			msps_pkg::ST_LOAD: begin
				state_n = after_st;
			end
			msps_pkg::ST_WDIV_GO: begin
				div_start = 1'b1;
				state_n   = msps_pkg::ST_WDIV;
			end
			msps_pkg::ST_WDIV: begin
				if (div_done) begin
					state_n = msps_pkg::ST_WSTORE;
				end
			end
			msps_pkg::ST_WSTORE: begin
				ram_we  = 1'b1;
				state_n = msps_pkg::ST_RB_RD;
			end
			msps_pkg::ST_RB_RD: begin
				state_n = msps_pkg::ST_RB_MUL;
			end
			msps_pkg::ST_RB_MUL: begin
				state_n = (span == '0) ? msps_pkg::ST_DONE : msps_pkg::ST_RB_DIV_GO;
			end
			msps_pkg::ST_RB_DIV_GO: begin
				div_start = 1'b1;
				state_n   = msps_pkg::ST_RB_DIV;
			end
			msps_pkg::ST_RB_DIV: begin
				if (div_done) begin
					state_n = msps_pkg::ST_DONE;
				end
			end
			msps_pkg::ST_DONE: begin
				if (load_out) begin
					state_n = msps_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = msps_pkg::ST_IDLE;
			end
		endcase
	end

	// Control and configuration state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q       <= msps_pkg::MIN_PULSE_RST;
			max_q       <= msps_pkg::MAX_PULSE_RST;
			def_q       <= msps_pkg::DEFAULT_PULSE_RST;
			period_q    <= msps_pkg::FRAME_PERIOD_RST;
			en_q        <= '0;
			vld_q       <= '0;
			slot_q      <= SLOT_IDLE;
			srch_q      <= '0;
			rem_q       <= '0;
			elapsed_q   <= '0;
			rd_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					msps_pkg::REG_MIN_PULSE:     min_q    <= cfg_data[msps_pkg::PULSE_W-1:0];
					msps_pkg::REG_MAX_PULSE:     max_q    <= cfg_data[msps_pkg::PULSE_W-1:0];
					msps_pkg::REG_DEFAULT_PULSE: def_q    <= cfg_data[msps_pkg::PULSE_W-1:0];
					msps_pkg::REG_FRAME_PERIOD:  period_q <= cfg_data[msps_pkg::PERIOD_W-1:0];
					default: ;
				endcase
			end

			rd_vld_q <= vld_q[ram_raddr];

			case (state_q)
				msps_pkg::ST_EXEC: begin
					if (kind_q == msps_pkg::KIND_TICK) begin
						elapsed_q <= elapsed_inc;
						rem_q     <= rem_dec;
						if (tick_event) begin
							if (slot_q >= SLOT_IDLE) begin
								elapsed_q <= '0;
								srch_q    <= '0;
							end else begin
								srch_q <= slot_q + SLOT_W'(1);
							end
						end
					end else if (chan_ok && kind_q == msps_pkg::KIND_ENABLE) begin
						en_q[chan_idx]  <= 1'b1;
						vld_q[chan_idx] <= 1'b1;
					end else if (chan_ok && kind_q == msps_pkg::KIND_DISABLE) begin
						en_q[chan_idx] <= 1'b0;
					end
				end
				msps_pkg::ST_SEARCH: begin
					if (srch_end) begin
						slot_q <= SLOT_IDLE;
						rem_q  <= gap;
					end else if (en_q[srch_idx]) begin
						slot_q <= srch_q;
					end else begin
						srch_q <= srch_q + SLOT_W'(1);
					end
				end
				msps_pkg::ST_LOAD: begin
					rem_q <= {4'd0, pulse_rd};
				end
				msps_pkg::ST_WSTORE: begin
					vld_q[chan_idx] <= 1'b1;
				end
				default: ;
			endcase

			if (state_q == msps_pkg::ST_DONE && load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item and result payload.
	always_ff @(posedge clk) begin
		case (state_q)
			msps_pkg::ST_IDLE: begin
				if (in_valid) begin
					kind_q  <= kind;
					chan_q  <= channel;
					value_q <= value;
				end
			end
			msps_pkg::ST_EXEC: begin
				rb_pulse_q <= '0;
				rb_angle_q <= '0;
				rb_en_q    <= 1'b0;
				us_q       <= msps_pkg::US_W'(value_q);
				prod_q     <= wprod;
			end
			msps_pkg::ST_WDIV: begin
				if (div_done) begin
					us_q <= us_ang;
				end
			end
			msps_pkg::ST_RB_MUL: begin
				rb_pulse_q <= pulse_rd;
				rb_en_q    <= en_q[chan_idx];
				prod_q     <= rprod;
			end
			msps_pkg::ST_RB_DIV: begin
				if (div_done) begin
					rb_angle_q <= rb_angle_n;
				end
			end
			msps_pkg::ST_DONE: begin
				if (load_out) begin
					pins_q   <= pins_n;
					pch_q    <= slot5[msps_pkg::CHAN_W-1:0];
					opulse_q <= rb_pulse_q;
					oangle_q <= rb_angle_q;
					oen_q    <= rb_en_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid        = out_valid_q;
	assign pin_levels       = pins_q;
	assign pulsing_channel  = pch_q;
	assign readback_pulse   = opulse_q;
	assign readback_angle   = oangle_q;
	assign readback_enabled = oen_q;

	// The active slot is a channel or the idle code, never beyond it.
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= SLOT_IDLE)
		else $error("slot register beyond idle code");

	// A finished division only arrives while the sequencer waits for it.
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == msps_pkg::ST_WDIV || state_q == msps_pkg::ST_RB_DIV))
		else $error("divider finished outside a wait state");

	// At most one pin is high in any delivered result.
	a_one_pin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0(pin_levels))
		else $error("more than one servo pin high");

	// The readback angle stays inside the degree range.
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> readback_angle <= msps_pkg::ANGLE_MAX)
		else $error("readback angle out of range");

endmodule

// File: test/multichannel_servo_pulse_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multichannel servo pulse sequencer testbench
// Starts with a short table of directed items. Some of them carry a hand-typed
// expected result. The others are checked against a behavioral model of the
// slot sequencer. A series of random phases follows, each under its own
// register setting. Both handshakes get random gaps and stalls.
// ----------------------------------------------------------------------------
module multichannel_servo_pulse_sequencer_tb;

	import msps_pkg::*;

	localparam int NCH      = CHANNELS_DEF;
	localparam int DIR_ROWS = 30;
	localparam int PHASES   = 6;

	typedef struct packed {
		logic [PINS-1:0]    pins;
		logic [CHAN_W-1:0]  slot;
		logic [PULSE_W-1:0] pulse;
		logic [ANGLE_W-1:0] angle;
		logic               en;
	} servo_out_t;

	typedef struct packed {
		bit                   is_cfg;
		logic [CFG_IDX_W-1:0] idx;
		logic [KIND_W-1:0]    k;
		logic [CHAN_W-1:0]    ch;
		logic [VALUE_W-1:0]   v;
		bit                   chk;
		servo_out_t           want;
	} dir_row_t;

	localparam servo_out_t NO_RES = '0;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic [KIND_W-1:0]          kind = KIND_TICK;
	logic [CHAN_W-1:0]          channel = '0;
	logic signed [VALUE_W-1:0]  value = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [PINS-1:0]            pin_levels;
	logic [CHAN_W-1:0]          pulsing_channel;
	logic [PULSE_W-1:0]         readback_pulse;
	logic [ANGLE_W-1:0]         readback_angle;
	logic                       readback_enabled;
	logic                       cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index = REG_MIN_PULSE;
	logic [CFG_DATA_W-1:0]      cfg_data = '0;

	multichannel_servo_pulse_sequencer u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.kind             (kind),
		.channel          (channel),
		.value            (value),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.pin_levels       (pin_levels),
		.pulsing_channel  (pulsing_channel),
		.readback_pulse   (readback_pulse),
		.readback_angle   (readback_angle),
		.readback_enabled (readback_enabled),
		.cfg_wen          (cfg_wen),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Model of the sequencer state and its registers.
	logic [PULSE_W-1:0]  m_min = MIN_PULSE_RST;
	logic [PULSE_W-1:0]  m_max = MAX_PULSE_RST;
	logic [PULSE_W-1:0]  m_def = DEFAULT_PULSE_RST;
	logic [PERIOD_W-1:0] m_period = FRAME_PERIOD_RST;
	bit                  m_en [NCH];
	logic [PULSE_W-1:0]  m_pulse [NCH];
	int                  m_slot = NCH;
	int                  m_remain = 0;
	int                  m_elapsed = 0;

	servo_out_t pending_results [$];
	int         fail_count = 0;
	int         burst_left = 0;

	initial begin
		for (int i = 0; i < NCH; i++) begin
			m_en[i] = 1'b0;
			m_pulse[i] = '0;
		end
	end

	function automatic servo_out_t predict_servo_step(input logic [KIND_W-1:0] k,
			input logic [CHAN_W-1:0] ch, input logic signed [VALUE_W-1:0] v);
		servo_out_t r;
		int c, us, a, span;
		bit ok;
		ok = ch < NCH;
		if (k == KIND_TICK) begin
			if (m_elapsed < int'(ELAPSED_MAX))
				m_elapsed++;
			if (m_remain > 0)
				m_remain--;
			if (m_remain == 0) begin
				if (m_slot >= NCH) begin
					m_elapsed = 0;
					c = 0;
				end else begin
					c = m_slot + 1;
				end
				while (c < NCH && !m_en[c])
					c++;
				if (c < NCH) begin
					m_slot = c;
					m_remain = m_pulse[c];
				end else begin
					m_slot = NCH;
					m_remain = (m_elapsed < int'(m_period)) ? int'(m_period) - m_elapsed : 0;
				end
			end
		end else if (ok) begin
			case (k)
				KIND_ENABLE: begin
					m_en[ch] = 1'b1;
					m_pulse[ch] = m_def;
				end
				KIND_DISABLE: begin
					m_en[ch] = 1'b0;
				end
				default: begin
					if (int'(v) < int'(ANGLE_LIMIT)) begin
						a = int'(v);
						if (a < 0)
							a = 0;
						if (a > int'(ANGLE_MAX))
							a = int'(ANGLE_MAX);
						us = int'(m_min) + (int'(m_max) - int'(m_min)) * a / int'(ANGLE_MAX);
					end else begin
						us = int'(v);
					end
					if (us < int'(m_min))
						us = int'(m_min);
					if (us > int'(m_max))
						us = int'(m_max);
					m_pulse[ch] = us[PULSE_W-1:0];
				end
			endcase
		end
		r = '0;
		r.pins = (m_slot < NCH) ? PINS'(1 << m_slot) : '0;
		r.slot = m_slot[CHAN_W-1:0];
		if (ok) begin
			span = int'(m_max) - int'(m_min);
			r.pulse = m_pulse[ch];
			r.en = m_en[ch];
			if (span != 0) begin
				a = (int'(m_pulse[ch]) - int'(m_min)) * int'(ANGLE_MAX) / span;
				if (a < 0)
					a = 0;
				if (a > int'(ANGLE_MAX))
					a = int'(ANGLE_MAX);
				r.angle = a[ANGLE_W-1:0];
			end
		end
		return r;
	endfunction

	task automatic send_item(input logic [KIND_W-1:0] k, input logic [CHAN_W-1:0] ch,
			input logic [VALUE_W-1:0] v, input bit chk, input servo_out_t typed);
		servo_out_t pred;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 30);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		kind <= k;
		channel <= ch;
		value <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pred = predict_servo_step(k, ch, v);
		pending_results.push_back(chk ? typed : pred);
	endtask

	// Stop sending and wait until every pending result has come back.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			REG_MIN_PULSE:     m_min = data[PULSE_W-1:0];
			REG_MAX_PULSE:     m_max = data[PULSE_W-1:0];
			REG_DEFAULT_PULSE: m_def = data[PULSE_W-1:0];
			default:           m_period = data[PERIOD_W-1:0];
		endcase
		@(posedge clk);
	endtask

	// Receiver: alternates between always ready, random ready and full stalls.
	int unsigned rdy_mode = 0;
	int unsigned rdy_left = 0;

	always @(posedge clk) begin
		if (rdy_left == 0) begin
			rdy_mode = $urandom_range(0, 2);
			rdy_left = $urandom_range(1, 40);
		end else begin
			rdy_left--;
		end
		case (rdy_mode)
			0:       out_ready <= 1'b1;
			1:       out_ready <= ($urandom_range(0, 99) < 60);
			default: out_ready <= 1'b0;
		endcase
	end

	always @(posedge clk) begin
		servo_out_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = '{pin_levels, pulsing_channel, readback_pulse, readback_angle,
				readback_enabled};
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result transfer: pins %h slot %0d pulse %0d",
						got.pins, got.slot, got.pulse);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					fail_count++;
					if (fail_count <= 10)
						$display({"mismatch (expected/actual): pins %h/%h slot %0d/%0d ",
							"pulse %0d/%0d angle %0d/%0d enabled %0d/%0d"},
							want.pins, got.pins, want.slot, got.slot, want.pulse, got.pulse,
							want.angle, got.angle, want.en, got.en);
				end
			end
		end
	end

	dir_row_t dir_rows [DIR_ROWS] = '{
		'{1'b0, REG_MIN_PULSE, KIND_ENABLE,  4'd0,  16'd0,     1'b1, '{12'd0, 4'd12, 12'd1500, 8'd92, 1'b1}},
		'{1'b0, REG_MIN_PULSE, KIND_WRITE,   4'd0,  16'd180,   1'b1, '{12'd0, 4'd12, 12'd2400, 8'd180, 1'b1}},
		'{1'b0, REG_MIN_PULSE, KIND_WRITE,   4'd0,  16'd0,     1'b1, '{12'd0, 4'd12, 12'd544, 8'd0, 1'b1}},
		'{1'b0, REG_MIN_PULSE, KIND_WRITE,   4'd0,  16'h8000,  1'b1, '{12'd0, 4'd12, 12'd544, 8'd0, 1'b1}},
		'{1'b0, REG_MIN_PULSE, KIND_WRITE,   4'd0,  16'h7FFF,  1'b1, '{12'd0, 4'd12, 12'd2400, 8'd180, 1'b1}},
		'{1'b0, REG_MIN_PULSE, KIND_WRITE,   4'd0,  16'd199,   1'b1, '{12'd0, 4'd12, 12'd2400, 8'd180, 1'b1}},
		'{1'b0, REG_MIN_PULSE, KIND_WRITE,   4'd0,  16'd200,   1'b1, '{12'd0, 4'd12, 12'd544, 8'd0, 1'b1}},
		'{1'b0, REG_MIN_PULSE, KIND_WRITE,   4'd0,  16'd1000,  1'b1, '{12'd0, 4'd12, 12'd1000, 8'd44, 1'b1}},
		'{1'b0, REG_MIN_PULSE, KIND_ENABLE,  4'd11, 16'd0,     1'b1, '{12'd0, 4'd12, 12'd1500, 8'd92, 1'b1}},
		'{1'b0, REG_MIN_PULSE, KIND_DISABLE, 4'd11, 16'd0,     1'b1, '{12'd0, 4'd12, 12'd1500, 8'd92, 1'b0}},
		'{1'b0, REG_MIN_PULSE, KIND_ENABLE,  4'd15, 16'hFFFF,  1'b1, '{12'd0, 4'd12, 12'd0, 8'd0, 1'b0}},
		'{1'b0, REG_MIN_PULSE, KIND_WRITE,   4'd12, 16'd1000,  1'b1, '{12'd0, 4'd12, 12'd0, 8'd0, 1'b0}},
		'{1'b1, REG_MIN_PULSE,     KIND_TICK, 4'd0, 16'hF000, 1'b0, NO_RES},
		'{1'b1, REG_MAX_PULSE,     KIND_TICK, 4'd0, 16'd3,    1'b0, NO_RES},
		'{1'b1, REG_DEFAULT_PULSE, KIND_TICK, 4'd0, 16'd0,    1'b0, NO_RES},
		'{1'b1, REG_FRAME_PERIOD,  KIND_TICK, 4'd0, 16'd6,    1'b0, NO_RES},
		'{1'b0, REG_MIN_PULSE, KIND_ENABLE,  4'd1, 16'd0,   1'b0, NO_RES},
		'{1'b0, REG_MIN_PULSE, KIND_ENABLE,  4'd5, 16'd0,   1'b0, NO_RES},
		'{1'b0, REG_MIN_PULSE, KIND_WRITE,   4'd5, 16'd180, 1'b0, NO_RES},
		'{1'b0, REG_MIN_PULSE, KIND_WRITE,   4'd0, 16'd120, 1'b0, NO_RES},
		'{1'b0, REG_MIN_PULSE, KIND_TICK,    4'd0, 16'd0,   1'b0, NO_RES},
		'{1'b0, REG_MIN_PULSE, KIND_TICK,    4'd0, 16'd0,   1'b0, NO_RES},
		'{1'b0, REG_MIN_PULSE, KIND_WRITE,   4'd0, 16'd250, 1'b0, NO_RES},
		'{1'b0, REG_MIN_PULSE, KIND_TICK,    4'd1, 16'd0,   1'b0, NO_RES},
		'{1'b0, REG_MIN_PULSE, KIND_TICK,    4'd5, 16'd0,   1'b0, NO_RES},
		'{1'b0, REG_MIN_PULSE, KIND_DISABLE, 4'd5, 16'd0,   1'b0, NO_RES},
		'{1'b0, REG_MIN_PULSE, KIND_TICK,    4'd0, 16'd0,   1'b0, NO_RES},
		'{1'b0, REG_MIN_PULSE, KIND_TICK,    4'd0, 16'd0,   1'b0, NO_RES},
		'{1'b0, REG_MIN_PULSE, KIND_TICK,    4'd0, 16'd0,   1'b0, NO_RES},
		'{1'b0, REG_MIN_PULSE, KIND_TICK,    4'd0, 16'd0,   1'b0, NO_RES}
	};

	// Register settings per random phase: min, max, default, frame period.
	int phase_cfg [PHASES][4] = '{
		'{10, 40, 20, 200},
		'{0, 4095, 0, 1},
		'{50, 20, 30, 100},
		'{25, 25, 25, 300},
		'{4095, 4095, 4095, 65535},
		'{1, 12, 7, 60}
	};
	int phase_items [PHASES] = '{220, 220, 220, 220, 100, 220};

	initial begin
		logic [KIND_W-1:0]  rk;
		logic [CHAN_W-1:0]  rch;
		logic [VALUE_W-1:0] rv;
		int sel, lo, hi;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_rows[i].is_cfg) begin
				settle();
				write_reg(dir_rows[i].idx, dir_rows[i].v);
			end else begin
				send_item(dir_rows[i].k, dir_rows[i].ch, dir_rows[i].v, dir_rows[i].chk,
					dir_rows[i].want);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			settle();
			write_reg(REG_MIN_PULSE, {4'($urandom), 12'(phase_cfg[p][0])});
			write_reg(REG_MAX_PULSE, {4'($urandom), 12'(phase_cfg[p][1])});
			write_reg(REG_DEFAULT_PULSE, {4'($urandom), 12'(phase_cfg[p][2])});
			write_reg(REG_FRAME_PERIOD, 16'(phase_cfg[p][3]));
			for (int n = 0; n < phase_items[p]; n++) begin
				sel = $urandom_range(0, 99);
				if (sel < 55)
					rk = KIND_TICK;
				else if (sel < 67)
					rk = KIND_ENABLE;
				else if (sel < 77)
					rk = KIND_DISABLE;
				else
					rk = KIND_WRITE;
				if ($urandom_range(0, 99) < 8)
					rch = 4'($urandom_range(NCH, 15));
				else
					rch = 4'($urandom_range(0, NCH - 1));
				sel = $urandom_range(0, 9);
				lo = (m_min < m_max) ? int'(m_min) : int'(m_max);
				hi = (m_min < m_max) ? int'(m_max) : int'(m_min);
				lo = (lo > 8) ? lo - 8 : 0;
				if (sel == 0) begin
					rv = 16'($urandom);
				end else if (sel == 1) begin
					case ($urandom_range(0, 7))
						0:       rv = 16'h8000;
						1:       rv = 16'h7FFF;
						2:       rv = 16'hFFFF;
						3:       rv = 16'd199;
						4:       rv = 16'd200;
						5:       rv = 16'd180;
						6:       rv = 16'd181;
						default: rv = 16'd0;
					endcase
				end else if (sel < 6) begin
					rv = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 180))
						: 16'($urandom_range(0, 4));
				end else begin
					rv = 16'($urandom_range(lo, hi + 8));
				end
				send_item(rk, rch, rv, 1'b0, NO_RES);
			end
		end

		settle();
		if (fail_count == 0 && pending_results.size() == 0)
			$display("** multichannel_servo_pulse_sequencer: PASSED **");
		else
			$display("** multichannel_servo_pulse_sequencer: FAILED **");
		$finish;
	end

	initial begin
		#30_000_000;
		$display("** multichannel_servo_pulse_sequencer: FAILED **");
		$finish;
	end

endmodule
